// ===== rtl/bkdt_pkg.sv =====
// bkdt_pkg: sizes, status and opcode codes, and shared structs of the dead tuple bitmap store
// depends on nothing; used by the interfaces and every rtl module of the block

package bkdt_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int BITMAP_BYTES = 65536;
    localparam int MAX_OFFSET   = 2048;

    localparam int KEY_W   = 32;
    localparam int OFF_W   = 12;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W  = $clog2(BITMAP_BYTES);
    localparam int FREE_W  = ADDR_W + 1;
    localparam int WORD_W  = OFF_W - 3;
    localparam int WORDS   = (MAX_OFFSET + 7) / 8;
    localparam int LEN_W   = $clog2(WORDS + 1);

    localparam logic [FREE_W-1:0] BYTES_LIM  = FREE_W'(BITMAP_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(BITMAP_BYTES - 1);
    localparam logic [CNT_W-1:0]  BLOCKS_LIM = CNT_W'(MAX_BLOCKS);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_BITMAP_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT     = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic             go;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_scan_cmd;

    typedef struct packed {
        logic   done;
        logic   hit;
        t_entry entry;
    } t_scan_res;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_entry_wr;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_bm_req;

endpackage

// ===== rtl/bkdt_req_if.sv =====
// bkdt_req_if: request channel of the store (valid, ready, add or lookup payload)
// depends on bkdt_pkg for field widths

interface bkdt_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [bkdt_pkg::KEY_W-1:0] block_number;
    logic [bkdt_pkg::OFF_W-1:0] tuple_offset;
    logic                       last_of_block;

    modport source (output valid, opcode, block_number, tuple_offset, last_of_block,
                    input ready);
    modport sink   (input valid, opcode, block_number, tuple_offset, last_of_block,
                    output ready);
endinterface

// ===== rtl/bkdt_rsp_if.sv =====
// bkdt_rsp_if: response channel of the store (valid, ready, is_dead and status)
// depends on bkdt_pkg for field widths

interface bkdt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        is_dead;
    logic [bkdt_pkg::STAT_W-1:0] status;

    modport source (output valid, is_dead, status, input ready);
    modport sink   (input valid, is_dead, status, output ready);
endinterface

// ===== rtl/block_keyed_dead_tuple_bitmap_store_core.sv =====
// Dead tuple bitmap store keyed by block number. Adds set bit (offset-1) of the block's
// packed slice in a shared byte memory; lookups return that bit, 0 for a missing block or
// an offset past the slice. One transaction in, one response out, one item at a time; the
// next request is taken while a response still waits in the output register. After reset
// the bitmap memory is zeroed, one byte a cycle, over all BITMAP_BYTES (65536) bytes, and
// no request is taken until that pass ends. An add to the block that is already open goes
// through decode with the byte read, byte write and response; an out-of-range offset goes
// from decode straight to the response. A lookup, or the first add of a block, scans the
// entry memory for the key one entry per cycle, up to a match (all stored entries on a
// miss), so that scan sets the rate.
// Depends on bkdt_pkg, bkdt_req_if, bkdt_rsp_if, bkdt_entry_table and bkdt_bitmap_mem.

module block_keyed_dead_tuple_bitmap_store_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bkdt_req_if.sink   i_req,
    bkdt_rsp_if.source o_rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LBIT   = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    // control state
    logic [2:0]                  r_state,     n_state;
    logic                        r_open_valid, n_open_valid;
    logic [bkdt_pkg::CNT_W-1:0]  r_count,     n_count;
    logic [bkdt_pkg::FREE_W-1:0] r_next_free, n_next_free;
    logic                        r_out_vld,   n_out_vld;

    // payload
    logic                         r_op,         n_op;
    logic [bkdt_pkg::KEY_W-1:0]   r_blk,        n_blk;
    logic [bkdt_pkg::OFF_W-1:0]   r_off,        n_off;
    logic                         r_last,       n_last;
    logic [bkdt_pkg::IDX_W-1:0]   r_open_idx,   n_open_idx;
    logic [bkdt_pkg::KEY_W-1:0]   r_open_key,   n_open_key;
    logic [bkdt_pkg::ADDR_W-1:0]  r_open_start, n_open_start;
    logic [bkdt_pkg::LEN_W-1:0]   r_open_len,   n_open_len;
    logic [bkdt_pkg::ADDR_W-1:0]  r_pos,        n_pos;
    logic                         r_res_dead,   n_res_dead;
    logic [bkdt_pkg::STAT_W-1:0]  r_res_stat,   n_res_stat;
    logic                         r_out_dead,   n_out_dead;
    logic [bkdt_pkg::STAT_W-1:0]  r_out_stat,   n_out_stat;

    logic [bkdt_pkg::OFF_W-1:0]  off_m1;
    logic [bkdt_pkg::WORD_W-1:0] word;
    logic [2:0]                  bitn;
    logic                        off_ok;
    logic                        open_hit;
    logic [bkdt_pkg::FREE_W-1:0] open_pos;
    logic [bkdt_pkg::FREE_W-1:0] free_pos;
    logic [bkdt_pkg::FREE_W-1:0] ent_pos;
    logic [bkdt_pkg::LEN_W-1:0]  wp1;
    logic [bkdt_pkg::LEN_W-1:0]  new_len;

    bkdt_pkg::t_scan_cmd scan_cmd;
    bkdt_pkg::t_scan_res scan_res;
    bkdt_pkg::t_entry_wr ent_wr;
    bkdt_pkg::t_bm_req   bm_req;
    logic [7:0]          bm_rd_data;
    logic                bm_ready;

    bkdt_entry_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (scan_cmd),
        .o_res   (scan_res),
        .i_wr    (ent_wr)
    );

    bkdt_bitmap_mem u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bm_req),
        .o_rd_data (bm_rd_data),
        .o_ready   (bm_ready)
    );

    assign i_req.ready   = (r_state == S_IDLE) && bm_ready;
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.is_dead = r_out_dead;
    assign o_rsp.status  = r_out_stat;

    assign off_m1   = r_off - bkdt_pkg::OFF_W'(1);
    assign word     = off_m1[bkdt_pkg::OFF_W-1:3];
    assign bitn     = off_m1[2:0];
    assign off_ok   = (r_off != '0) && (32'(r_off) <= 32'(bkdt_pkg::MAX_OFFSET));
    assign open_hit = r_open_valid && (r_open_key == r_blk);
    assign open_pos = bkdt_pkg::FREE_W'(r_open_start) + bkdt_pkg::FREE_W'(word);
    assign free_pos = r_next_free + bkdt_pkg::FREE_W'(word);
    assign ent_pos  = bkdt_pkg::FREE_W'(scan_res.entry.start) + bkdt_pkg::FREE_W'(word);
    assign wp1      = bkdt_pkg::LEN_W'(word) + bkdt_pkg::LEN_W'(1);
    assign new_len  = (wp1 > r_open_len) ? wp1 : r_open_len;

    always_comb begin
        n_state      = r_state;
        n_open_valid = r_open_valid;
        n_count      = r_count;
        n_next_free  = r_next_free;
        n_out_vld    = r_out_vld;
        n_op         = r_op;
        n_blk        = r_blk;
        n_off        = r_off;
        n_last       = r_last;
        n_open_idx   = r_open_idx;
        n_open_key   = r_open_key;
        n_open_start = r_open_start;
        n_open_len   = r_open_len;
        n_pos        = r_pos;
        n_res_dead   = r_res_dead;
        n_res_stat   = r_res_stat;
        n_out_dead   = r_out_dead;
        n_out_stat   = r_out_stat;

        scan_cmd.go    = 1'b0;
        scan_cmd.key   = r_blk;
        scan_cmd.count = r_count;

        ent_wr.en          = 1'b0;
        ent_wr.idx         = r_open_idx;
        ent_wr.entry.key   = r_open_key;
        ent_wr.entry.start = r_open_start;
        ent_wr.entry.len   = new_len;

        bm_req.rd    = 1'b0;
        bm_req.wr    = 1'b0;
        bm_req.addr  = r_pos;
        bm_req.wdata = bm_rd_data | (8'h01 << bitn);

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_op    = i_req.opcode;
                    n_blk   = i_req.block_number;
                    n_off   = i_req.tuple_offset;
                    n_last  = i_req.last_of_block;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_dead = 1'b0;
                n_res_stat = bkdt_pkg::ST_OK;
                if (!off_ok) begin
                    n_state = S_RESULT;
                end else if (r_op == bkdt_pkg::OP_LOOKUP) begin
                    scan_cmd.go = 1'b1;
                    n_state     = S_SCAN;
                end else if (open_hit) begin
                    if (open_pos >= bkdt_pkg::BYTES_LIM) begin
                        n_res_stat = bkdt_pkg::ST_BITMAP_FULL;
                        n_state    = S_RESULT;
                    end else begin
                        bm_req.rd   = 1'b1;
                        bm_req.addr = open_pos[bkdt_pkg::ADDR_W-1:0];
                        n_pos       = open_pos[bkdt_pkg::ADDR_W-1:0];
                        n_state     = S_WRITE;
                    end
                end else begin
                    // a different block closes the open one at its current length
                    if (r_open_valid) begin
                        n_next_free  = bkdt_pkg::FREE_W'(r_open_start)
                                     + bkdt_pkg::FREE_W'(r_open_len);
                        n_open_valid = 1'b0;
                    end
                    scan_cmd.go = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    if (r_op == bkdt_pkg::OP_LOOKUP) begin
                        if (!scan_res.hit
                            || (32'(word) >= 32'(scan_res.entry.len))
                            || (ent_pos >= bkdt_pkg::BYTES_LIM)) begin
                            n_state = S_RESULT;
                        end else begin
                            bm_req.rd   = 1'b1;
                            bm_req.addr = ent_pos[bkdt_pkg::ADDR_W-1:0];
                            n_state     = S_LBIT;
                        end
                    end else if (scan_res.hit) begin
                        n_res_stat = bkdt_pkg::ST_PRESENT;
                        n_state    = S_RESULT;
                    end else if (r_count >= bkdt_pkg::BLOCKS_LIM) begin
                        n_res_stat = bkdt_pkg::ST_TABLE_FULL;
                        n_state    = S_RESULT;
                    end else if (free_pos >= bkdt_pkg::BYTES_LIM) begin
                        n_res_stat = bkdt_pkg::ST_BITMAP_FULL;
                        n_state    = S_RESULT;
                    end else begin
                        // open a new entry at the next free byte
                        n_open_valid = 1'b1;
                        n_open_idx   = r_count[bkdt_pkg::IDX_W-1:0];
                        n_open_key   = r_blk;
                        n_open_start = r_next_free[bkdt_pkg::ADDR_W-1:0];
                        n_open_len   = '0;
                        n_count      = r_count + bkdt_pkg::CNT_W'(1);
                        bm_req.rd    = 1'b1;
                        bm_req.addr  = free_pos[bkdt_pkg::ADDR_W-1:0];
                        n_pos        = free_pos[bkdt_pkg::ADDR_W-1:0];
                        n_state      = S_WRITE;
                    end
                end
            end
            S_LBIT: begin
                n_res_dead = bm_rd_data[bitn];
                n_state    = S_RESULT;
            end
            S_WRITE: begin
                bm_req.wr  = 1'b1;
                ent_wr.en  = 1'b1;
                n_open_len = new_len;
                if (r_last) begin
                    n_next_free  = bkdt_pkg::FREE_W'(r_open_start)
                                 + bkdt_pkg::FREE_W'(new_len);
                    n_open_valid = 1'b0;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_dead = r_res_dead;
                    n_out_stat = r_res_stat;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_open_valid <= 1'b0;
            r_count      <= '0;
            r_next_free  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_open_valid <= n_open_valid;
            r_count      <= n_count;
            r_next_free  <= n_next_free;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_blk        <= n_blk;
        r_off        <= n_off;
        r_last       <= n_last;
        r_open_idx   <= n_open_idx;
        r_open_key   <= n_open_key;
        r_open_start <= n_open_start;
        r_open_len   <= n_open_len;
        r_pos        <= n_pos;
        r_res_dead   <= n_res_dead;
        r_res_stat   <= n_res_stat;
        r_out_dead   <= n_out_dead;
        r_out_stat   <= n_out_stat;
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded next cycle");

    a_open_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_valid |-> (bkdt_pkg::CNT_W'(r_open_idx) + bkdt_pkg::CNT_W'(1) == r_count))
        else $error("open entry is not the newest entry");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= bkdt_pkg::BYTES_LIM)
        else $error("free pointer past the bitmap memory");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bkdt_pkg::BLOCKS_LIM)
        else $error("entry count past the table size");

    a_write_has_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> r_open_valid)
        else $error("bitmap write without an open entry");

endmodule

// ===== rtl/bkdt_entry_table.sv =====
// bkdt_entry_table: entry memory (key, slice start, slice length) with a linear key scan
// depends on bkdt_pkg for sizes and the scan and write structs

module bkdt_entry_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bkdt_pkg::t_scan_cmd i_cmd,
    output bkdt_pkg::t_scan_res o_res,
    input  bkdt_pkg::t_entry_wr i_wr
);

    bkdt_pkg::t_entry r_mem [bkdt_pkg::MAX_BLOCKS];

    bkdt_pkg::t_entry                r_rd_data;
    logic                            r_rd_vld;
    logic                            r_busy;
    logic [bkdt_pkg::CNT_W-1:0]      r_ptr;
    logic [bkdt_pkg::CNT_W-1:0]      r_count;
    logic [bkdt_pkg::KEY_W-1:0]      r_key;

    logic hit;
    logic more;
    logic issue;
    logic done;

    // keys are unique, so the first match ends the scan
    assign hit   = r_rd_vld && (r_rd_data.key == r_key);
    assign more  = r_ptr < r_count;
    assign issue = r_busy && more && !hit;
    assign done  = r_busy && (hit || (!more && !r_rd_vld));

    assign o_res.done  = done;
    assign o_res.hit   = hit;
    assign o_res.entry = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.go) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_ptr   <= '0;
            r_count <= i_cmd.count;
            r_key   <= i_cmd.key;
        end else if (issue) begin
            r_ptr <= r_ptr + bkdt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_ptr[bkdt_pkg::IDX_W-1:0]];
        end
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> !r_busy)
        else $error("scan started while one is running");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ptr <= r_count))
        else $error("scan pointer ran past the entry count");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> !r_busy && !r_rd_vld)
        else $error("scan kept running after completion");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_wr.en)
        else $error("entry written during a scan");

endmodule

// ===== rtl/bkdt_bitmap_mem.sv =====
// bkdt_bitmap_mem: shared bitmap byte memory with a zeroing pass after reset
// depends on bkdt_pkg for the memory size and the request struct

module bkdt_bitmap_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bkdt_pkg::t_bm_req i_req,
    output logic [7:0]        o_rd_data,
    output logic              o_ready
);

    logic [7:0] r_mem [bkdt_pkg::BITMAP_BYTES];

    logic                        r_clr_active;
    logic [bkdt_pkg::ADDR_W-1:0] r_clr_addr;
    logic [7:0]                  r_rd_data;

    assign o_ready   = !r_clr_active;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == bkdt_pkg::LAST_ADDR) begin
                r_clr_active <= 1'b0;
                r_clr_addr   <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + bkdt_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    a_idle_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_req.rd && !i_req.wr)
        else $error("bitmap accessed during the zeroing pass");

    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.rd && i_req.wr))
        else $error("bitmap read and write in the same cycle");

    a_clear_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> (r_clr_addr == '0))
        else $error("zeroing pass ended with a stale address");

endmodule
